@@ rtl/srte_pkg.sv @@
// srte_pkg: shared constants, types and codes for the sorted region table engine
// depends on: nothing
package srte_pkg;

    localparam int MAX_REGIONS = 128;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = $clog2(MAX_REGIONS + 2);
    localparam int RAM_AW      = IDX_W + 2;
    localparam int RAM_DEPTH   = 4 * (2 ** IDX_W);
    localparam int DATA_W      = 128;

    localparam logic [63:0] ADDR_TOP = {64{1'b1}};

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_LIMIT  = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_SETUP,
        OP_INIT,
        OP_READ,
        OP_ADD_NEW,
        OP_ADD_REG,
        OP_REM_REG,
        OP_REM_HI,
        OP_WALK_LEN,
        OP_WALK_STEP,
        OP_FLUSH,
        OP_COMMIT,
        OP_FAIL,
        OP_CUT,
        OP_DONE
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DISPATCH,
        ST_A_FETCH,
        ST_A_PROC,
        ST_A_TAIL,
        ST_A_FLUSH,
        ST_A_CHECK,
        ST_R_FETCH,
        ST_R_PROC,
        ST_R_HI,
        ST_W_FETCH,
        ST_W_LEN,
        ST_W_STEP,
        ST_E_CHECK,
        ST_E_INIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op  op;
        logic tbl;
    } t_cmd;

    typedef struct packed {
        logic  more;
        logic  ins_first;
        logic  ins_done;
        logic  rem_hi;
        logic  found;
        logic  cut_top;
        logic  zero;
        logic  add_over;
        logic  room_sel;
        logic  room_both;
        t_func func;
        logic  tsel;
    } t_sts;

endpackage

@@ rtl/sorted_region_table_engine.sv @@
// sorted_region_table_engine: top level, controller plus datapath
// depends on: srte_pkg, srte_ctrl, srte_datapath
//
//  channel   signals                                         transfer
//  command   start, busy, i_func, i_table_sel, i_base,       start && !busy
//            i_size
//  result    o_valid, o_status, o_region_count,              o_valid (one cycle)
//            o_total_bytes
//
//  one command at a time; busy stays high until the result strobe
//  add and remove make one pass over the regions held (up to 128), limit walks
//  table 0 and may then rebuild both; each region is one read of the table ram
//  tables are rebuilt into a second bank of the ram and swapped on success
//  reset is synchronous: both tables return to one empty dummy entry at once
//  results cannot be stalled
module sorted_region_table_engine
    import srte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic        i_table_sel,
    input  logic [63:0] i_base,
    input  logic [63:0] i_size,
    output logic        o_valid,
    output logic        o_status,
    output logic [7:0]  o_region_count,
    output logic [63:0] o_total_bytes
);

    t_cmd cmd;
    t_sts sts;

    srte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    srte_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_func         (i_func),
        .i_table_sel    (i_table_sel),
        .i_base         (i_base),
        .i_size         (i_size),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_region_count (o_region_count),
        .o_total_bytes  (o_total_bytes)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_end_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_idle_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |-> (cmd.op == OP_NOP))
        else $error("datapath command issued while idle");

endmodule

@@ rtl/srte_ram.sv @@
// srte_ram: generic single write port, single read port ram with registered read
// depends on: nothing
module srte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/srte_datapath.sv @@
// srte_datapath: region tables, streaming rebuild of one table per pass, result registers
// depends on: srte_pkg, srte_ram
module srte_datapath
    import srte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_func,
    input  logic        i_table_sel,
    input  logic [63:0] i_base,
    input  logic [63:0] i_size,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_valid,
    output logic        o_status,
    output logic [7:0]  o_region_count,
    output logic [63:0] o_total_bytes
);

    // control state
    logic [1:0][CNT_W-1:0] r_count, n_count;
    logic [1:0]            r_empty, n_empty;
    logic [1:0]            r_bank, n_bank;
    logic                  r_o_valid, n_o_valid;
    // payload state
    logic [1:0][63:0]      r_total, n_total;
    t_func                 r_func, n_func;
    logic                  r_tsel, n_tsel;
    logic [63:0]           r_b, n_b, r_s, n_s, r_end, n_end;
    logic                  r_zero, n_zero;
    logic                  r_pt, n_pt;
    logic [CNT_W-1:0]      r_ridx, n_ridx, r_widx, n_widx, r_nr, n_nr;
    logic [63:0]           r_se, n_se, r_sb, n_sb, r_pb, n_pb, r_pe, n_pe, r_cb, n_cb;
    logic [63:0]           r_lim, n_lim, r_len, n_len, r_cut, n_cut;
    logic                  r_pv, n_pv, r_insd, n_insd, r_brk, n_brk, r_found, n_found;
    logic                  r_status, n_status;
    logic                  r_o_status, n_o_status;
    logic [7:0]            r_o_count, n_o_count;
    logic [63:0]           r_o_total, n_o_total;

    logic [DATA_W-1:0] ram_rdata;
    logic              ram_we, ram_re;
    logic [63:0]       q_b, q_e;
    logic [CNT_W-1:0]  stream_cnt;
    logic              overlap, tail_gap;
    logic              emit_en, feed_en;
    logic [63:0]       emit_b, emit_e, feed_b, feed_e;
    logic              rep;

    assign q_b        = ram_rdata[127:64];
    assign q_e        = ram_rdata[63:0];
    assign stream_cnt = r_empty[r_pt] ? '0 : r_count[r_pt];
    assign overlap    = (q_e > r_b) && (q_b < r_end);
    assign tail_gap   = r_cb < r_end;
    assign rep        = (r_func == FUNC_LIMIT) ? 1'b0 : r_tsel;

    always_comb begin
        o_sts.more      = r_ridx < stream_cnt;
        o_sts.ins_first = !r_insd && (r_b <= q_b);
        o_sts.ins_done  = r_insd;
        o_sts.rem_hi    = overlap && (q_e > r_end);
        o_sts.found     = r_found;
        o_sts.cut_top   = r_cut == ADDR_TOP;
        o_sts.zero      = r_zero;
        o_sts.add_over  = ({1'b0, r_count[r_pt]} + {1'b0, r_nr}
                          + (CNT_W+1)'(tail_gap)) > (CNT_W+1)'(MAX_REGIONS);
        o_sts.room_sel  = ({1'b0, r_count[r_tsel]} + (CNT_W+1)'(2))
                          <= (CNT_W+1)'(MAX_REGIONS);
        o_sts.room_both = (({1'b0, r_count[0]} + (CNT_W+1)'(2))
                          <= (CNT_W+1)'(MAX_REGIONS))
                          && (({1'b0, r_count[1]} + (CNT_W+1)'(2))
                          <= (CNT_W+1)'(MAX_REGIONS));
        o_sts.func      = r_func;
        o_sts.tsel      = r_tsel;
    end

    always_comb begin
        n_count = r_count;   n_empty = r_empty;   n_bank = r_bank;   n_total = r_total;
        n_func = r_func;     n_tsel = r_tsel;     n_b = r_b;         n_s = r_s;
        n_end = r_end;       n_zero = r_zero;     n_pt = r_pt;       n_ridx = r_ridx;
        n_widx = r_widx;     n_nr = r_nr;         n_se = r_se;       n_sb = r_sb;
        n_pb = r_pb;         n_pe = r_pe;         n_cb = r_cb;       n_lim = r_lim;
        n_len = r_len;       n_cut = r_cut;       n_pv = r_pv;       n_insd = r_insd;
        n_brk = r_brk;       n_found = r_found;   n_status = r_status;
        n_o_valid = 1'b0;    n_o_status = r_o_status;
        n_o_count = r_o_count;
        n_o_total = r_o_total;
        ram_re  = 1'b0;
        emit_en = 1'b0;      emit_b = r_pb;       emit_e = r_pe;
        feed_en = 1'b0;      feed_b = q_b;        feed_e = q_e;

        unique case (i_cmd.op)
            OP_LATCH: begin
                n_func   = t_func'(i_func);
                n_tsel   = i_table_sel;
                n_b      = i_base;
                n_s      = i_size;
                n_status = 1'b0;
            end
            OP_SETUP: begin
                if (r_func == FUNC_LIMIT) begin
                    n_zero = r_s == 64'd0;
                end else begin
                    n_zero = (r_s == 64'd0) || (r_b == ADDR_TOP);
                end
                n_end = (r_s < ~r_b) ? (r_b + r_s) : ADDR_TOP;
            end
            OP_INIT: begin
                n_pt    = i_cmd.tbl;
                n_ridx  = '0;
                n_widx  = '0;
                n_nr    = '0;
                n_se    = '0;
                n_sb    = '0;
                n_pv    = 1'b0;
                n_insd  = 1'b0;
                n_brk   = 1'b0;
                n_cb    = r_b;
                n_lim   = r_s;
                n_found = 1'b0;
                n_cut   = ADDR_TOP;
            end
            OP_READ: begin
                ram_re = 1'b1;
                n_ridx = r_ridx + 1'b1;
            end
            OP_ADD_NEW: begin
                feed_en = 1'b1;
                feed_b  = r_b;
                feed_e  = r_end;
                n_insd  = 1'b1;
            end
            OP_ADD_REG: begin
                feed_en = 1'b1;
                if (!r_brk) begin
                    if (q_b >= r_end) begin
                        n_brk = 1'b1;
                    end else if (q_e > r_cb) begin
                        if (q_b > r_cb) begin
                            n_nr = r_nr + 1'b1;
                        end
                        n_cb = (q_e < r_end) ? q_e : r_end;
                    end
                end
            end
            OP_REM_REG: begin
                if (!overlap) begin
                    emit_en = 1'b1;
                    emit_b  = q_b;
                    emit_e  = q_e;
                end else if (q_b < r_b) begin
                    emit_en = 1'b1;
                    emit_b  = q_b;
                    emit_e  = r_b;
                end
            end
            OP_REM_HI: begin
                emit_en = 1'b1;
                emit_b  = r_end;
                emit_e  = q_e;
            end
            OP_WALK_LEN: begin
                n_len = q_e - q_b;
            end
            OP_WALK_STEP: begin
                if (!r_found) begin
                    if (r_lim <= r_len) begin
                        n_found = 1'b1;
                        n_cut   = q_b + r_lim;
                    end else begin
                        n_lim = r_lim - r_len;
                    end
                end
            end
            OP_FLUSH: begin
                emit_en = r_pv;
                n_pv    = 1'b0;
            end
            OP_COMMIT: begin
                n_bank[r_pt] = ~r_bank[r_pt];
                if (r_widx == '0) begin
                    n_count[r_pt] = CNT_W'(1);
                    n_empty[r_pt] = 1'b1;
                    n_total[r_pt] = '0;
                end else begin
                    n_count[r_pt] = r_widx;
                    n_empty[r_pt] = 1'b0;
                    n_total[r_pt] = r_se - r_sb;
                end
            end
            OP_FAIL: begin
                n_status = 1'b1;
            end
            OP_CUT: begin
                n_b   = r_cut;
                n_end = ADDR_TOP;
            end
            OP_DONE: begin
                n_o_valid  = 1'b1;
                n_o_status = r_status;
                n_o_count  = 8'(r_count[rep]);
                n_o_total  = r_total[rep];
            end
            OP_NOP: begin
            end
            default: begin
            end
        endcase

        // merge accumulator for add
        if (feed_en) begin
            if (!r_pv) begin
                n_pv = 1'b1;
                n_pb = feed_b;
                n_pe = feed_e;
            end else if (feed_b <= r_pe) begin
                if (feed_e > r_pe) begin
                    n_pe = feed_e;
                end
            end else begin
                emit_en = 1'b1;
                n_pb    = feed_b;
                n_pe    = feed_e;
            end
        end

        if (emit_en) begin
            n_widx = r_widx + 1'b1;
            n_se   = r_se + emit_e;
            n_sb   = r_sb + emit_b;
        end
    end

    assign ram_we = emit_en && (r_widx < CNT_W'(MAX_REGIONS));

    srte_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ({r_pt, ~r_bank[r_pt], r_widx[IDX_W-1:0]}),
        .i_wdata ({emit_b, emit_e}),
        .i_re    (ram_re),
        .i_raddr ({r_pt, r_bank[r_pt], r_ridx[IDX_W-1:0]}),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= {CNT_W'(1), CNT_W'(1)};
            r_empty   <= 2'b11;
            r_bank    <= 2'b00;
            r_total   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_empty   <= n_empty;
            r_bank    <= n_bank;
            r_total   <= n_total;
            r_o_valid <= n_o_valid;
        end
        r_func     <= n_func;
        r_tsel     <= n_tsel;
        r_b        <= n_b;
        r_s        <= n_s;
        r_end      <= n_end;
        r_zero     <= n_zero;
        r_pt       <= n_pt;
        r_ridx     <= n_ridx;
        r_widx     <= n_widx;
        r_nr       <= n_nr;
        r_se       <= n_se;
        r_sb       <= n_sb;
        r_pb       <= n_pb;
        r_pe       <= n_pe;
        r_cb       <= n_cb;
        r_lim      <= n_lim;
        r_len      <= n_len;
        r_cut      <= n_cut;
        r_pv       <= n_pv;
        r_insd     <= n_insd;
        r_brk      <= n_brk;
        r_found    <= n_found;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
        r_o_total  <= n_o_total;
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_region_count = r_o_count;
    assign o_total_bytes  = r_o_total;

endmodule

@@ rtl/srte_ctrl.sv @@
// srte_ctrl: sequencing state machine, issues one datapath command per cycle
// depends on: srte_pkg
module srte_ctrl
    import srte_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    t_state r_state, n_state;
    logic   r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        o_cmd.op  = OP_NOP;
        o_cmd.tbl = 1'b0;
        busy      = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.op = OP_SETUP;
                n_state  = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                n_state = ST_DONE;
                case (i_sts.func)
                    FUNC_ADD: begin
                        if (!i_sts.zero) begin
                            o_cmd.op  = OP_INIT;
                            o_cmd.tbl = i_sts.tsel;
                            n_state   = ST_A_FETCH;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (!i_sts.zero) begin
                            if (!i_sts.room_sel) begin
                                o_cmd.op = OP_FAIL;
                            end else begin
                                o_cmd.op  = OP_INIT;
                                o_cmd.tbl = i_sts.tsel;
                                n_state   = ST_R_FETCH;
                            end
                        end
                    end
                    FUNC_LIMIT: begin
                        if (!i_sts.zero) begin
                            o_cmd.op = OP_INIT;
                            n_state  = ST_W_FETCH;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_A_FETCH: begin
                if (i_sts.more) begin
                    o_cmd.op = OP_READ;
                    n_state  = ST_A_PROC;
                end else begin
                    n_state = ST_A_TAIL;
                end
            end
            ST_A_PROC: begin
                if (i_sts.ins_first) begin
                    o_cmd.op = OP_ADD_NEW;
                end else begin
                    o_cmd.op = OP_ADD_REG;
                    n_state  = ST_A_FETCH;
                end
            end
            ST_A_TAIL: begin
                if (!i_sts.ins_done) begin
                    o_cmd.op = OP_ADD_NEW;
                end
                n_state = ST_A_FLUSH;
            end
            ST_A_FLUSH: begin
                o_cmd.op = OP_FLUSH;
                n_state  = ST_A_CHECK;
            end
            ST_A_CHECK: begin
                o_cmd.op = i_sts.add_over ? OP_FAIL : OP_COMMIT;
                n_state  = ST_DONE;
            end
            ST_R_FETCH: begin
                if (i_sts.more) begin
                    o_cmd.op = OP_READ;
                    n_state  = ST_R_PROC;
                end else begin
                    o_cmd.op = OP_COMMIT;
                    if ((i_sts.func == FUNC_LIMIT) && !r_phase) begin
                        n_phase = 1'b1;
                        n_state = ST_E_INIT;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_R_PROC: begin
                o_cmd.op = OP_REM_REG;
                n_state  = i_sts.rem_hi ? ST_R_HI : ST_R_FETCH;
            end
            ST_R_HI: begin
                o_cmd.op = OP_REM_HI;
                n_state  = ST_R_FETCH;
            end
            ST_W_FETCH: begin
                if (i_sts.more && !i_sts.found) begin
                    o_cmd.op = OP_READ;
                    n_state  = ST_W_LEN;
                end else begin
                    n_state = ST_E_CHECK;
                end
            end
            ST_W_LEN: begin
                o_cmd.op = OP_WALK_LEN;
                n_state  = ST_W_STEP;
            end
            ST_W_STEP: begin
                o_cmd.op = OP_WALK_STEP;
                n_state  = ST_W_FETCH;
            end
            ST_E_CHECK: begin
                n_state = ST_DONE;
                if (!i_sts.cut_top) begin
                    if (!i_sts.room_both) begin
                        o_cmd.op = OP_FAIL;
                    end else begin
                        o_cmd.op = OP_CUT;
                        n_phase  = 1'b0;
                        n_state  = ST_E_INIT;
                    end
                end
            end
            ST_E_INIT: begin
                o_cmd.op  = OP_INIT;
                o_cmd.tbl = r_phase;
                n_state   = ST_R_FETCH;
            end
            ST_DONE: begin
                o_cmd.op = OP_DONE;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ tb/srte_checker.sv @@
// srte_checker: transfer monitor, table predictor and result comparison
// depends on: srte_pkg, the command and result ports of sorted_region_table_engine
`timescale 1ns / 100ps
module srte_checker
    import srte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_func,
    input  logic        i_table_sel,
    input  logic [63:0] i_base,
    input  logic [63:0] i_size,
    input  logic        o_valid,
    input  logic        o_status,
    input  logic [7:0]  o_region_count,
    input  logic [63:0] o_total_bytes,
    output int          cmd_count,
    output int          res_count,
    output int          pending,
    output int          fail_count
);

    typedef struct packed {
        logic        status;
        logic [7:0]  count;
        logic [63:0] total;
    } t_summary;

    logic [63:0] reg_lo  [2][MAX_REGIONS];
    logic [63:0] reg_len [2][MAX_REGIONS];
    int          reg_cnt [2];
    logic [63:0] reg_sum [2];
    t_summary    summary_q[$];

    function automatic logic [63:0] clip_len(input logic [63:0] b, input logic [63:0] s);
        logic [63:0] room;
        room = ADDR_TOP - b;
        return (s < room) ? s : room;
    endfunction

    function automatic void clear_tables();
        for (int t = 0; t < 2; t++) begin
            for (int k = 0; k < MAX_REGIONS; k++) begin
                reg_lo[t][k]  = '0;
                reg_len[t][k] = '0;
            end
            reg_cnt[t] = 1;
            reg_sum[t] = '0;
        end
    endfunction

    function automatic void put_region(input bit t, input int idx, input logic [63:0] b,
                                       input logic [63:0] s);
        int n;
        n = reg_cnt[t];
        if (n >= MAX_REGIONS || idx > n) return;
        for (int k = n; k > idx; k--) begin
            reg_lo[t][k]  = reg_lo[t][k-1];
            reg_len[t][k] = reg_len[t][k-1];
        end
        reg_lo[t][idx]  = b;
        reg_len[t][idx] = s;
        reg_cnt[t] = n + 1;
        reg_sum[t] = reg_sum[t] + s;
    endfunction

    function automatic void drop_region(input bit t, input int idx);
        int n;
        n = reg_cnt[t];
        if (n == 0 || idx >= n || n > MAX_REGIONS) return;
        reg_sum[t] = reg_sum[t] - reg_len[t][idx];
        for (int k = idx; k < n - 1; k++) begin
            reg_lo[t][k]  = reg_lo[t][k+1];
            reg_len[t][k] = reg_len[t][k+1];
        end
        n--;
        if (n == 0) begin
            n = 1;
            reg_lo[t][0]  = '0;
            reg_len[t][0] = '0;
        end
        reg_cnt[t] = n;
    endfunction

    function automatic void merge_regions(input bit t);
        int n, i;
        n = reg_cnt[t];
        i = 0;
        while (i + 1 < n && i + 1 < MAX_REGIONS) begin
            if (reg_lo[t][i] + reg_len[t][i] == reg_lo[t][i+1]) begin
                reg_len[t][i] = reg_len[t][i] + reg_len[t][i+1];
                for (int k = i + 1; k < n - 1; k++) begin
                    reg_lo[t][k]  = reg_lo[t][k+1];
                    reg_len[t][k] = reg_len[t][k+1];
                end
                n--;
            end else begin
                i++;
            end
        end
        reg_cnt[t] = n;
    endfunction

    function automatic int fill_gaps(input bit t, input logic [63:0] b_in,
                                     input logic [63:0] end_a, input bit doins);
        int nr, i;
        logic [63:0] b, rb, re;
        nr = 0;
        i  = 0;
        b  = b_in;
        while (i < reg_cnt[t] && i < MAX_REGIONS) begin
            rb = reg_lo[t][i];
            re = rb + reg_len[t][i];
            if (rb >= end_a) break;
            if (re <= b) begin
                i++;
                continue;
            end
            if (rb > b) begin
                nr++;
                if (doins) begin
                    put_region(t, i, b, rb - b);
                    i++;
                end
            end
            b = (re < end_a) ? re : end_a;
            i++;
        end
        if (b < end_a) begin
            nr++;
            if (doins) put_region(t, i, b, end_a - b);
        end
        return nr;
    endfunction

    function automatic logic add_region(input bit t, input logic [63:0] b,
                                        input logic [63:0] s_in);
        logic [63:0] s, end_a;
        int nr;
        s = clip_len(b, s_in);
        if (s == 0) return 1'b0;
        end_a = b + s;
        if (reg_len[t][0] == 0) begin
            reg_lo[t][0]  = b;
            reg_len[t][0] = s;
            reg_sum[t]    = s;
            return 1'b0;
        end
        nr = fill_gaps(t, b, end_a, 1'b0);
        if (reg_cnt[t] + nr > MAX_REGIONS) return 1'b1;
        nr = fill_gaps(t, b, end_a, 1'b1);
        merge_regions(t);
        return 1'b0;
    endfunction

    function automatic logic carve_region(input bit t, input logic [63:0] b,
                                          input logic [63:0] s_in);
        logic [63:0] s, end_a, rb, re;
        int i, first, last;
        s = clip_len(b, s_in);
        if (s == 0) return 1'b0;
        if (reg_cnt[t] + 2 > MAX_REGIONS) return 1'b1;
        end_a = b + s;
        i = 0;
        first = 0;
        last = 0;
        while (i < reg_cnt[t] && i < MAX_REGIONS) begin
            rb = reg_lo[t][i];
            re = rb + reg_len[t][i];
            if (rb >= end_a) break;
            if (re <= b) begin
                i++;
                continue;
            end
            if (rb < b) begin
                reg_lo[t][i]  = b;
                reg_len[t][i] = reg_len[t][i] - (b - rb);
                reg_sum[t]    = reg_sum[t] - (b - rb);
                put_region(t, i, rb, b - rb);
                i++;
            end else if (re > end_a) begin
                reg_lo[t][i]  = end_a;
                reg_len[t][i] = reg_len[t][i] - (end_a - rb);
                reg_sum[t]    = reg_sum[t] - (end_a - rb);
                put_region(t, i, rb, end_a - rb);
            end else begin
                if (last == 0) first = i;
                last = i + 1;
                i++;
            end
        end
        for (int k = last; k > first; k--) drop_region(t, k - 1);
        return 1'b0;
    endfunction

    function automatic logic cap_memory(input logic [63:0] limit_in);
        logic [63:0] cut, limit;
        logic dummy;
        cut = ADDR_TOP;
        limit = limit_in;
        if (limit == 0) return 1'b0;
        for (int i = 0; i < reg_cnt[0] && i < MAX_REGIONS; i++) begin
            if (limit <= reg_len[0][i]) begin
                cut = reg_lo[0][i] + limit;
                break;
            end
            limit = limit - reg_len[0][i];
        end
        if (clip_len(cut, ADDR_TOP) != 0 &&
            (reg_cnt[0] + 2 > MAX_REGIONS || reg_cnt[1] + 2 > MAX_REGIONS))
            return 1'b1;
        dummy = carve_region(1'b0, cut, ADDR_TOP);
        dummy = carve_region(1'b1, cut, ADDR_TOP);
        return 1'b0;
    endfunction

    function automatic t_summary apply_command(input t_func f, input bit t,
                                               input logic [63:0] b, input logic [63:0] s);
        t_summary r;
        bit rep;
        rep = t;
        r.status = 1'b0;
        case (f)
            FUNC_ADD:    r.status = add_region(t, b, s);
            FUNC_REMOVE: r.status = carve_region(t, b, s);
            FUNC_LIMIT: begin
                r.status = cap_memory(s);
                rep = 1'b0;
            end
            default: ;
        endcase
        r.count = reg_cnt[rep][7:0];
        r.total = reg_sum[rep];
        return r;
    endfunction

    initial begin
        clear_tables();
        cmd_count  = 0;
        res_count  = 0;
        pending    = 0;
        fail_count = 0;
    end

    always @(posedge i_clk) begin
        t_summary got, want;
        if (!i_rst_n) begin
            clear_tables();
            summary_q.delete();
        end else begin
            if (o_valid) begin
                res_count <= res_count + 1;
                got = '{o_status, o_region_count, o_total_bytes};
                if (summary_q.size() == 0) begin
                    $error("unexpected result transfer");
                    fail_count = fail_count + 1;
                end else begin
                    want = summary_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d got %0d", want.status, got.status);
                        fail_count = fail_count + 1;
                    end
                    if (got.count !== want.count) begin
                        $error("region_count: expected %0d got %0d", want.count, got.count);
                        fail_count = fail_count + 1;
                    end
                    if (got.total !== want.total) begin
                        $error("total_bytes: expected %h got %h", want.total, got.total);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                cmd_count <= cmd_count + 1;
                summary_q.push_back(apply_command(t_func'(i_func), i_table_sel, i_base, i_size));
            end
        end
        pending <= summary_q.size();
    end

endmodule

@@ tb/tb.sv @@
// tb: stimulus and verdict for sorted_region_table_engine
// depends on: srte_pkg, sorted_region_table_engine, srte_checker
`timescale 1ns / 100ps
module tb;
    import srte_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_func = FUNC_ADD;
    logic        i_table_sel = 1'b0;
    logic [63:0] i_base = '0;
    logic [63:0] i_size = '0;
    logic        o_valid;
    logic        o_status;
    logic [7:0]  o_region_count;
    logic [63:0] o_total_bytes;
    int          cmd_count, res_count, pending, fail_count;
    int          quiet, last_cmd, last_res;
    bit          no_idle;

    always #1 i_clk = ~i_clk;

    sorted_region_table_engine uut (.*);
    srte_checker u_chk (.*);

    initial begin
        quiet = 0;
        last_cmd = 0;
        last_res = 0;
    end

    always @(negedge i_clk) begin
        if (cmd_count != last_cmd || res_count != last_res) quiet <= 0;
        else quiet <= quiet + 1;
        last_cmd <= cmd_count;
        last_res <= res_count;
        if (quiet >= WATCHDOG) begin
            $display("FAIL sorted_region_table_engine");
            $finish;
        end
    end

    task automatic send(input t_func f, input bit t, input logic [63:0] b,
                        input logic [63:0] s);
        int gap, seen;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_func = f;
        i_table_sel = t;
        i_base = b;
        i_size = s;
        seen = cmd_count;
        do @(negedge i_clk); while (cmd_count == seen);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] near_base();
        return 64'($urandom_range(0, 511)) * 8 + 64'($urandom_range(0, 3));
    endfunction

    function automatic logic [63:0] near_size();
        int p;
        p = $urandom_range(0, 99);
        if (p < 5) return '0;
        if (p < 10) return rnd64();
        if (p < 13) return ADDR_TOP;
        return 64'($urandom_range(1, 40));
    endfunction

    task automatic random_item();
        int p;
        t_func f;
        logic [63:0] b, s;
        p = $urandom_range(0, 99);
        if (p < 55) f = FUNC_ADD;
        else if (p < 82) f = FUNC_REMOVE;
        else if (p < 94) f = FUNC_LIMIT;
        else f = FUNC_NONE;
        b = ($urandom_range(0, 9) == 0) ? rnd64() : near_base();
        s = near_size();
        if (f == FUNC_LIMIT && $urandom_range(0, 3) != 0) s = 64'($urandom_range(0, 3000));
        send(f, 1'($urandom_range(0, 1)), b, s);
    endtask

    task automatic fill_table(input bit t);
        for (int k = 0; k < 135; k++)
            send(FUNC_ADD, t, 64'h10_0000 + 64'(k) * 16 + 64'($urandom_range(0, 3)),
                 64'($urandom_range(1, 8)));
    endtask

    initial begin
        no_idle = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send(FUNC_NONE,   1'b0, 64'h0, 64'h0);
        send(FUNC_REMOVE, 1'b0, 64'h1000, 64'h100);
        send(FUNC_LIMIT,  1'b0, 64'h0, 64'h10);
        send(FUNC_ADD,    1'b0, 64'h1000, 64'h100);
        send(FUNC_ADD,    1'b0, 64'h1080, 64'h200);
        send(FUNC_ADD,    1'b0, 64'h1280, 64'h10);
        send(FUNC_ADD,    1'b0, 64'h800, 64'h0);
        send(FUNC_ADD,    1'b0, ADDR_TOP, ADDR_TOP);
        send(FUNC_ADD,    1'b0, ADDR_TOP - 64'hf, ADDR_TOP);
        send(FUNC_ADD,    1'b0, 64'h2000, 64'h40);
        send(FUNC_ADD,    1'b0, 64'h1f00, 64'h200);
        send(FUNC_REMOVE, 1'b0, 64'h1100, 64'h20);
        send(FUNC_REMOVE, 1'b0, 64'h1100, 64'h0);
        send(FUNC_ADD,    1'b1, 64'h1040, 64'h80);
        send(FUNC_ADD,    1'b1, 64'h3000, 64'h10);
        send(FUNC_NONE,   1'b1, 64'h0, 64'h0);
        send(FUNC_LIMIT,  1'b0, 64'h0, 64'h0);
        send(FUNC_LIMIT,  1'b0, 64'h0, ADDR_TOP);
        send(FUNC_LIMIT,  1'b0, 64'h0, 64'h180);
        send(FUNC_REMOVE, 1'b1, 64'h0, ADDR_TOP);
        send(FUNC_REMOVE, 1'b0, 64'h0, ADDR_TOP);
        send(FUNC_ADD,    1'b0, 64'h0, ADDR_TOP);
        send(FUNC_REMOVE, 1'b0, 64'h0, ADDR_TOP);

        for (int seg = 0; seg < 3; seg++) begin
            no_idle = (seg == 1);
            fill_table(seg[0]);
            send(FUNC_ADD, seg[0], 64'h10_0003, 64'h400);
            send(FUNC_REMOVE, seg[0], 64'h10_0020, 64'h4);
            send(FUNC_LIMIT, 1'b0, 64'h0, 64'h100);
            for (int k = 0; k < 20; k++) random_item();
            if (seg == 2) begin
                start = 1'b0;
                while (pending != 0) @(negedge i_clk);
                repeat (3) @(negedge i_clk);
            end
            send(FUNC_REMOVE, seg[0], 64'h0, ADDR_TOP);
        end
        no_idle = 1'b0;
        for (int k = 0; k < 80; k++) random_item();

        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (1200) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS sorted_region_table_engine");
        end else begin
            $display("FAIL sorted_region_table_engine");
        end
        $finish;
    end

endmodule
